/* design/sssd_pkg.sv */
// ----------------------------------------------------------------------
// sssd_pkg
// shared types, codes and helpers of the self-synchronizing scrambler
// ----------------------------------------------------------------------
package sssd_pkg;

   // default order limit of the polynomial scan
   localparam int MAX_ORDER_DEF = 31;
   // default shift register width, min(MAX_ORDER_DEF, 32)
   localparam int REG_W_DEF     = (MAX_ORDER_DEF < 32) ? MAX_ORDER_DEF : 32;

   localparam int BYTE_BITS     = 8;
   localparam int POLY_W        = 32;
   localparam int TAP_W         = 5;
   localparam int DC_W          = 6;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   // operation codes
   localparam logic [1:0] OP_SCRAMBLE   = 2'd0;
   localparam logic [1:0] OP_DESCRAMBLE = 2'd1;
   localparam logic [1:0] OP_FLUSH      = 2'd2;

   // register indexes
   typedef enum logic [1:0] {
      REG_POLYNOMIAL = 2'd0,
      REG_INVERT     = 2'd1,
      REG_WORD_WIDTH = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [POLY_W-1:0] polynomial;
      logic              invert;
      logic [3:0]        word_width;
   } cfg_type;

   typedef struct packed {
      logic             busy;
      logic [TAP_W-1:0] top;
      logic [TAP_W-1:0] second;
      logic [TAP_W-1:0] delay;
   } taps_type;

   // ones in the low n bits of a byte, n up to 8
   function automatic logic [7:0] low_mask(input logic [3:0] n);
      logic [8:0] m;
      m = (9'd1 << n) - 9'd1;
      return m[7:0];
   endfunction

endpackage

/* design/sssd_if.sv */
// ----------------------------------------------------------------------
// sssd_if
// valid/ready channels for request and response transactions
// ----------------------------------------------------------------------
interface sssd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data;
   logic [3:0] bit_count;
   logic       new_call;
   logic       prime;

   modport source (output valid, operation, data, bit_count, new_call, prime, input ready);
   modport sink   (input valid, operation, data, bit_count, new_call, prime, output ready);
endinterface

interface sssd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_word;
   logic [3:0] valid_bits;
   logic       last_of_run;

   modport source (output valid, out_word, valid_bits, last_of_run, input ready);
   modport sink   (input valid, out_word, valid_bits, last_of_run, output ready);
endinterface

/* design/sssd_csr.sv */
// ----------------------------------------------------------------------
// sssd_csr
// apb register file: polynomial, invert, word width
// ----------------------------------------------------------------------
module sssd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sssd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sssd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sssd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output sssd_pkg::cfg_type                cfg,
   output logic                             poly_written
);
   import sssd_pkg::*;

   logic [POLY_W-1:0] poly_ff, poly_in;
   logic              invert_ff, invert_in;
   logic [3:0]        width_ff, width_in;
   logic              wr;
   reg_index_type     index;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      poly_in      = poly_ff;
      invert_in    = invert_ff;
      width_in     = width_ff;
      poly_written = 1'b0;
      csr_prdata   = '0;
      unique case (index)
         REG_POLYNOMIAL: begin
            csr_prdata = CSR_DATA_W'(poly_ff);
            if (wr) begin
               poly_in      = csr_pwdata[POLY_W-1:0];
               poly_written = 1'b1;
            end
         end
         REG_INVERT: begin
            csr_prdata = CSR_DATA_W'(invert_ff);
            if (wr) begin
               invert_in = csr_pwdata[0];
            end
         end
         REG_WORD_WIDTH: begin
            csr_prdata = CSR_DATA_W'(width_ff);
            if (wr) begin
               width_in = csr_pwdata[3:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff   <= POLY_W'(3);
         invert_ff <= 1'b0;
         width_ff  <= 4'd8;
      end else begin
         poly_ff   <= poly_in;
         invert_ff <= invert_in;
         width_ff  <= width_in;
      end
   end

   assign cfg.polynomial = poly_ff;
   assign cfg.invert     = invert_ff;
   assign cfg.word_width = width_ff;

endmodule

/* design/sssd_tap_scan.sv */
// ----------------------------------------------------------------------
// sssd_tap_scan
// serial search of the polynomial for its input and output taps
// ----------------------------------------------------------------------
module sssd_tap_scan #(
   parameter int REG_W = sssd_pkg::REG_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sssd_pkg::POLY_W-1:0]   polynomial,
   output sssd_pkg::taps_type            taps
);
   import sssd_pkg::*;

   localparam int IDX_W = $clog2(REG_W);

   logic             busy_ff, busy_in;
   logic [REG_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       hits_ff, hits_in;
   logic [TAP_W-1:0] top_ff, top_in;
   logic [TAP_W-1:0] second_ff, second_in;
   logic [TAP_W-1:0] delay_ff, delay_in;

   logic             hit, last;
   logic [TAP_W-1:0] idx_ext, top_n, sec_n, sec_final;
   logic [1:0]       hits_n;

   always_comb begin
      hit       = scan_ff[0];
      last      = (idx_ff == IDX_W'(REG_W - 1));
      idx_ext   = TAP_W'(idx_ff);
      top_n     = hit ? idx_ext : top_ff;
      sec_n     = (hit && hits_ff == 2'd1) ? idx_ext : second_ff;
      hits_n    = (hit && hits_ff != 2'd2) ? hits_ff + 2'd1 : hits_ff;
      // fewer than two taps: output tap falls on the input tap
      sec_final = (hits_n < 2'd2) ? top_n : sec_n;

      busy_in   = busy_ff;
      scan_in   = scan_ff;
      idx_in    = idx_ff;
      hits_in   = hits_ff;
      top_in    = top_ff;
      second_in = second_ff;
      delay_in  = delay_ff;

      if (start) begin
         busy_in   = 1'b1;
         scan_in   = polynomial[REG_W-1:0];
         idx_in    = '0;
         hits_in   = '0;
         top_in    = '0;
         second_in = '0;
      end else if (busy_ff) begin
         scan_in = scan_ff >> 1;
         idx_in  = idx_ff + 1'b1;
         hits_in = hits_n;
         top_in  = top_n;
         if (last) begin
            busy_in   = 1'b0;
            second_in = sec_final;
            delay_in  = top_n - sec_final;
         end else begin
            second_in = sec_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         top_ff    <= TAP_W'(1);
         second_ff <= TAP_W'(1);
         delay_ff  <= '0;
         hits_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         top_ff    <= top_in;
         second_ff <= second_in;
         delay_ff  <= delay_in;
         hits_ff   <= hits_in;
         idx_ff    <= idx_in;
      end
      scan_ff <= scan_in;
   end

   assign taps.busy   = busy_ff;
   assign taps.top    = top_ff;
   assign taps.second = second_ff;
   assign taps.delay  = delay_ff;

endmodule

/* design/sssd_engine.sv */
// ----------------------------------------------------------------------
// sssd_engine
// bit-serial shift register, word packing and response register
// ----------------------------------------------------------------------
module sssd_engine #(
   parameter int REG_W = sssd_pkg::REG_W_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  sssd_pkg::cfg_type   cfg,
   input  sssd_pkg::taps_type  taps,
   sssd_req_if.sink            req,
   sssd_rsp_if.source          rsp
);
   import sssd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_SCRAMBLE   = 6'b000010,
      ST_DESCRAMBLE = 6'b000100,
      ST_FLUSH      = 6'b001000,
      ST_TAIL       = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [REG_W-1:0] sr_ff, sr_in;
   logic [REG_W-1:0] sr_save_ff, sr_save_in;
   logic [DC_W-1:0]  dc_ff, dc_in;
   logic [DC_W-1:0]  dc_save_ff, dc_save_in;
   logic [7:0]       pw_ff, pw_in;
   logic [3:0]       pb_ff, pb_in;
   logic [7:0]       data_sh_ff, data_sh_in;
   logic [TAP_W-1:0] bits_left_ff, bits_left_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [7:0]       pend_word_ff, pend_word_in;
   logic [3:0]       pend_bits_ff, pend_bits_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_word_ff, out_word_in;
   logic [3:0]       out_bits_ff, out_bits_in;
   logic             out_last_ff, out_last_in;

   logic [REG_W-1:0] poly_used, in_mask, out_mask, reg_mask;
   logic [REG_W-1:0] s_base, s_set, s_scr, s_desc, sr_next;
   logic [3:0]       ww_eff, scr_cnt, desc_cnt, pb_inc;
   logic [DC_W-1:0]  new_dc;
   logic             in_bit, dob, ob, emit_en, word_done, out_free, stall, accept;
   logic [7:0]       pw_cat, desc_word;
   logic             push, push_last;
   logic [7:0]       push_word;
   logic [3:0]       push_bits;

   assign req.ready = (state_ff == ST_IDLE) && !taps.busy;
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // tap masks and per-bit datapath
   always_comb begin
      ww_eff    = (cfg.word_width == 4'd0) ? 4'd1 :
                  (cfg.word_width > 4'd8) ? 4'd8 : cfg.word_width;
      scr_cnt   = (req.bit_count < ww_eff) ? req.bit_count : ww_eff;
      desc_cnt  = (req.bit_count < 4'(BYTE_BITS)) ? req.bit_count : 4'(BYTE_BITS);
      new_dc    = req.prime ? '0 : DC_W'(taps.delay);

      poly_used = cfg.polynomial[REG_W-1:0];
      in_mask   = REG_W'(1) << taps.top;
      out_mask  = REG_W'(1) << taps.second;
      reg_mask  = in_mask | (in_mask - REG_W'(1));

      in_bit    = data_sh_ff[7] ^ (cfg.invert & (state_ff == ST_SCRAMBLE));
      s_base    = sr_ff & reg_mask;
      s_set     = in_bit ? (s_base | in_mask) : s_base;
      s_scr     = s_set[0] ? (s_set ^ poly_used) : s_set;
      s_desc    = in_bit ? (s_base ^ poly_used) : s_base;
      dob       = s_desc[0] ^ cfg.invert;
      sr_next   = (((state_ff == ST_DESCRAMBLE) ? s_desc : s_scr) >> 1) & reg_mask;
      desc_word = {data_sh_ff[6:0], dob} & low_mask(cnt_ff);

      emit_en   = (dc_ff >= DC_W'(taps.delay));
      ob        = |(s_scr & out_mask);
      pw_cat    = {pw_ff[6:0], ob};
      pb_inc    = pb_ff + 4'd1;
      word_done = emit_en && (pb_inc >= ww_eff);
      stall     = word_done && pend_valid_ff && !out_free;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sr_in         = sr_ff;
      sr_save_in    = sr_save_ff;
      dc_in         = dc_ff;
      dc_save_in    = dc_save_ff;
      pw_in         = pw_ff;
      pb_in         = pb_ff;
      data_sh_in    = data_sh_ff;
      bits_left_in  = bits_left_ff;
      cnt_in        = cnt_ff;
      pend_word_in  = pend_word_ff;
      pend_bits_in  = pend_bits_ff;
      pend_valid_in = pend_valid_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      push_word     = pend_word_ff;
      push_bits     = pend_bits_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept) begin
               unique case (req.operation)
                  OP_SCRAMBLE: begin
                     if (req.new_call) begin
                        dc_in = new_dc;
                        pw_in = '0;
                        pb_in = '0;
                     end
                     data_sh_in   = req.data << (4'd8 - ww_eff);
                     bits_left_in = TAP_W'(scr_cnt);
                     state_in     = (scr_cnt == 4'd0) ? ST_FINISH : ST_SCRAMBLE;
                  end
                  OP_DESCRAMBLE: begin
                     data_sh_in   = req.data;
                     bits_left_in = TAP_W'(desc_cnt);
                     cnt_in       = desc_cnt;
                     if (desc_cnt != 4'd0) begin
                        state_in = ST_DESCRAMBLE;
                     end
                  end
                  OP_FLUSH: begin
                     if (req.new_call) begin
                        dc_in = new_dc;
                        pw_in = '0;
                        pb_in = '0;
                     end
                     dc_save_in   = req.new_call ? new_dc : dc_ff;
                     sr_save_in   = sr_ff;
                     data_sh_in   = '0;
                     bits_left_in = taps.delay;
                     state_in     = (taps.delay == '0) ? ST_TAIL : ST_FLUSH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCRAMBLE, ST_FLUSH: begin
            if (!stall) begin
               sr_in        = sr_next;
               data_sh_in   = {data_sh_ff[6:0], 1'b0};
               bits_left_in = bits_left_ff - 1'b1;
               if (emit_en) begin
                  if (word_done) begin
                     pw_in = '0;
                     pb_in = '0;
                     if (pend_valid_ff) begin
                        push = 1'b1;
                     end
                     pend_word_in  = pw_cat & low_mask(ww_eff);
                     pend_bits_in  = ww_eff;
                     pend_valid_in = 1'b1;
                  end else begin
                     pw_in = pw_cat;
                     pb_in = pb_inc;
                  end
               end else begin
                  dc_in = dc_ff + 1'b1;
               end
               if (bits_left_ff == TAP_W'(1)) begin
                  state_in = (state_ff == ST_FLUSH) ? ST_TAIL : ST_FINISH;
               end
            end
         end
         ST_DESCRAMBLE: begin
            sr_in        = sr_next;
            data_sh_in   = {data_sh_ff[6:0], dob};
            bits_left_in = bits_left_ff - 1'b1;
            if (bits_left_ff == TAP_W'(1)) begin
               pend_word_in  = desc_word;
               pend_bits_in  = cnt_ff;
               pend_valid_in = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_TAIL: begin
            if (!(pb_ff != 4'd0 && pend_valid_ff && !out_free)) begin
               if (pb_ff != 4'd0) begin
                  if (pend_valid_ff) begin
                     push = 1'b1;
                  end
                  pend_word_in  = pw_ff & low_mask(pb_ff);
                  pend_bits_in  = pb_ff;
                  pend_valid_in = 1'b1;
                  pw_in         = '0;
                  pb_in         = '0;
               end
               // the flush leaves the register and the delay counter untouched
               sr_in    = sr_save_ff;
               dc_in    = dc_save_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = push ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      out_word_in  = push ? push_word : out_word_ff;
      out_bits_in  = push ? push_bits : out_bits_ff;
      out_last_in  = push ? push_last : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sr_ff         <= '1;
         dc_ff         <= '0;
         pw_ff         <= '0;
         pb_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sr_ff         <= sr_in;
         dc_ff         <= dc_in;
         pw_ff         <= pw_in;
         pb_ff         <= pb_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sr_save_ff   <= sr_save_in;
      dc_save_ff   <= dc_save_in;
      data_sh_ff   <= data_sh_in;
      bits_left_ff <= bits_left_in;
      cnt_ff       <= cnt_in;
      pend_word_ff <= pend_word_in;
      pend_bits_ff <= pend_bits_in;
      out_word_ff  <= out_word_in;
      out_bits_ff  <= out_bits_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_word    = out_word_ff;
   assign rsp.valid_bits  = out_bits_ff;
   assign rsp.last_of_run = out_last_ff;

endmodule

/* design/self_sync_scrambler_descrambler.sv */
// ----------------------------------------------------------------------
// self_sync_scrambler_descrambler
// bit-serial multiplicative self-synchronizing scrambler and descrambler
// ----------------------------------------------------------------------
// The block runs one bit per clock when not stalled, through a feedback
// shift register whose taps come from the polynomial register: the input
// tap is its highest set bit below MAX_ORDER (capped at 32), the output
// tap its second-lowest set bit, and their distance is the output delay.
// A scramble transaction takes min(bit_count, word_width) bits MSB first
// and returns one response per completed output word; a descramble
// transaction takes min(bit_count, 8) bits from bit 7 down and returns
// one response when bit_count is nonzero; a flush pushes delay zero bits
// through, returns the remaining partial word, then puts the register and
// the delay counter back. The final response of each request carries
// last_of_run. A request is taken in the idle state, then its bits pass
// through the shift register loop, then a closing state hands over any
// pending response (a flush passes a tail state first); a back-pressured
// response port stalls the loop once a second word is waiting. The
// response register lets the next request in while the last response
// still waits. Writing the polynomial starts a tap search, one polynomial
// bit per cycle, during which no request is taken.
// ----------------------------------------------------------------------
module self_sync_scrambler_descrambler #(
   parameter int MAX_ORDER = sssd_pkg::MAX_ORDER_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request and response channels
   sssd_req_if.sink                         req,
   sssd_rsp_if.source                       rsp,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sssd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sssd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sssd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sssd_pkg::*;

   // shift register width: bits 0 up to the highest possible input tap
   localparam int REG_W = (MAX_ORDER < 32) ? MAX_ORDER : 32;

   cfg_type  cfg;
   taps_type taps;
   logic     poly_written;

   // configuration registers
   sssd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .cfg          (cfg),
      .poly_written (poly_written)
   );

   // tap search after each polynomial write
   // the search loads the value on the write bus, the register is not yet updated
   sssd_tap_scan #(
      .REG_W (REG_W)
   ) u_tap_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (poly_written),
      .polynomial (csr_pwdata),
      .taps       (taps)
   );

   // serial datapath and response register
   sssd_engine #(
      .REG_W (REG_W)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .taps  (taps),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// testbench
// self-checking bench for the self-synchronizing scrambler/descrambler
// ----------------------------------------------------------------------
// Request transactions go in over a valid/ready channel. A bit-level
// predictor of the scrambler tracks the shift register, the delay counter
// and the partial output word, and queues the words each request should
// return. A checker compares every response transaction, field by field,
// against the oldest queued word. Registers are written over the APB
// port only once the block has drained. A directed part comes first, then
// tap corner cases, randomized frames over many settings and a full-rate run.
// ----------------------------------------------------------------------
module testbench;
   import sssd_pkg::*;

   // opcode the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // most words one request can return
   localparam int MAX_WORDS = 32;
   // bits of the polynomial the tap search looks at
   localparam int SCAN_BITS = (MAX_ORDER_DEF < 32) ? MAX_ORDER_DEF : 32;
   // cycles to let pass once the last expected word is in (flush of 29 bits + margin)
   localparam int SETTLE_CYCLES = 40;
   // items for the randomized part
   localparam int RANDOM_ITEMS = 30;

   typedef struct packed {
      logic [7:0] word;
      logic [3:0] bits;
      logic       last;
   } scr_word_t;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sssd_req_if req_if ();
   sssd_rsp_if rsp_if ();

   self_sync_scrambler_descrambler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // scrambler predictor state
   // ------------------------------------------------------------------
   // register copies
   logic [31:0] cfg_poly;
   logic        cfg_inv;
   logic [3:0]  cfg_ww;
   // taps derived from the polynomial
   logic [31:0] poly_used;
   logic [31:0] in_mask;
   logic [31:0] out_mask;
   logic [31:0] reg_mask;
   int unsigned dly;
   // running state
   logic [31:0] sr;
   logic [5:0]  dcount;
   logic [7:0]  pword;
   logic [3:0]  pbits;

   // words of the request being predicted, and words still owed by the block
   scr_word_t item_words[$];
   scr_word_t due_words[$];

   int  mismatch_count = 0;
   int  items_count = 0;
   // when set, neither side inserts idle cycles
   bit  no_idle = 1'b0;

   function automatic logic [7:0] low_bits(input logic [7:0] w, input int unsigned n);
      logic [15:0] m;
      m = (16'd1 << n) - 16'd1;
      return w & m[7:0];
   endfunction

   // word width as the block uses it: 0 acts as 1, above 8 acts as 8
   function automatic int unsigned word_bits();
      if (cfg_ww == 4'd0) return 1;
      if (cfg_ww > 4'd8) return 8;
      return cfg_ww;
   endfunction

   // input tap = top set bit, output tap = second-lowest set bit
   task automatic derive_taps();
      int unsigned top;
      int unsigned second;
      int unsigned cnt;
      logic [63:0] wide;
      poly_used = cfg_poly & ((32'd1 << SCAN_BITS) - 32'd1);
      top = 0;
      second = 0;
      cnt = 0;
      for (int i = 0; i < SCAN_BITS; i++) begin
         if (poly_used[i]) begin
            if (cnt == 1) second = i;
            top = i;
            cnt++;
         end
      end
      // too few taps: output tap falls on the input tap, no delay
      if (cnt < 2) second = top;
      in_mask = 32'd1 << top;
      out_mask = 32'd1 << second;
      wide = (64'd2 << top) - 64'd1;
      reg_mask = wide[31:0];
      dly = top - second;
   endtask

   task automatic push_word(input logic [7:0] w, input logic [3:0] n);
      scr_word_t sw;
      // words past the limit are dropped
      if (item_words.size() < MAX_WORDS) begin
         sw = '{word: w, bits: n, last: 1'b0};
         item_words.push_back(sw);
      end
   endtask

   // one scrambler bit; output is held back while the delay counter runs
   task automatic scramble_bit(input logic b, input int unsigned ww);
      sr = sr & reg_mask;
      if (b) sr = sr | in_mask;
      if (sr[0]) sr = sr ^ poly_used;
      if (dcount >= dly) begin
         pword = {pword[6:0], |(sr & out_mask)};
         pbits = pbits + 4'd1;
         if (pbits >= ww) begin
            push_word(low_bits(pword, ww), ww[3:0]);
            pword = 8'd0;
            pbits = 4'd0;
         end
      end else begin
         dcount = dcount + 6'd1;
      end
      sr = (sr >> 1) & reg_mask;
   endtask

   // works out the words one accepted request returns and queues them
   task automatic predict_words(input logic [1:0] op, input logic [7:0] data,
                                input logic [3:0] bc, input logic nc, input logic pr);
      int unsigned ww;
      int unsigned cnt;
      logic [7:0]  res;
      logic        ob;
      logic [31:0] sr_keep;
      logic [5:0]  dc_keep;
      ww = word_bits();
      item_words.delete();
      if (op == OP_DESCRAMBLE) begin
         // descramble ignores new_call and prime, always byte-wide
         cnt = (bc < BYTE_BITS) ? bc : BYTE_BITS;
         res = 8'd0;
         for (int i = 0; i < cnt; i++) begin
            sr = sr & reg_mask;
            if (data[BYTE_BITS-1-i]) sr = sr ^ poly_used;
            ob = sr[0] ^ cfg_inv;
            res = {res[6:0], ob};
            sr = (sr >> 1) & reg_mask;
         end
         if (cnt > 0) push_word(res, cnt[3:0]);
      end else if (op != OP_UNUSED) begin
         // a new frame restarts the delay counter and drops the partial word
         if (nc) begin
            dcount = pr ? 6'd0 : dly[5:0];
            pword = 8'd0;
            pbits = 4'd0;
         end
         if (op == OP_SCRAMBLE) begin
            cnt = (bc < ww) ? bc : ww;
            for (int i = 0; i < cnt; i++) scramble_bit(data[ww-1-i] ^ cfg_inv, ww);
         end else begin
            // flush: push delay zeros, emit the partial word, then put state back
            sr_keep = sr;
            dc_keep = dcount;
            for (int i = 0; i < dly; i++) scramble_bit(1'b0, ww);
            if (pbits > 4'd0) begin
               push_word(low_bits(pword, pbits), pbits);
               pword = 8'd0;
               pbits = 4'd0;
            end
            sr = sr_keep;
            dcount = dc_keep;
         end
      end
      if (item_words.size() > 0) item_words[item_words.size()-1].last = 1'b1;
      foreach (item_words[i]) due_words.push_back(item_words[i]);
   endtask

   // ------------------------------------------------------------------
   // channel drivers
   // ------------------------------------------------------------------
   task automatic report_error(input string msg);
      if (mismatch_count < 100) $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // sends one request transaction; entered and left at a rising edge
   task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                            input logic [3:0] bc, input logic nc, input logic pr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.data      <= data;
      req_if.bit_count <= bc;
      req_if.new_call  <= nc;
      req_if.prime     <= pr;
      do @(posedge clock); while (!req_if.ready);
      predict_words(op, data, bc, nc, pr);
      if (op != OP_UNUSED) items_count++;
   endtask

   // sender holds off until every owed word has come back
   task automatic pause_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (due_words.size() != 0);
   endtask

   // drained and quiet: safe point for register writes
   task automatic settle();
      pause_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, access cycle, then the bus goes idle
   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_POLYNOMIAL: begin
            cfg_poly = value;
            derive_taps();
         end
         REG_INVERT:     cfg_inv = value[0];
         REG_WORD_WIDTH: cfg_ww = value[3:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] poly, input logic inv,
                                 input logic [3:0] ww);
      settle();
      write_reg(REG_POLYNOMIAL, poly);
      write_reg(REG_INVERT, {31'd0, inv});
      write_reg(REG_WORD_WIDTH, {28'd0, ww});
   endtask

   // response side: random stall per transaction
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // response checker against the oldest owed word
   always @(posedge clock) begin
      scr_word_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_words.size() == 0) begin
            report_error($sformatf("unexpected response word %02h bits %0d",
                                   rsp_if.out_word, rsp_if.valid_bits));
         end else begin
            want = due_words.pop_front();
            if (rsp_if.out_word !== want.word)
               report_error($sformatf("out_word %02h, expected %02h",
                                      rsp_if.out_word, want.word));
            if (rsp_if.valid_bits !== want.bits)
               report_error($sformatf("valid_bits %0d, expected %0d",
                                      rsp_if.valid_bits, want.bits));
            if (rsp_if.last_of_run !== want.last)
               report_error($sformatf("last_of_run %0b, expected %0b",
                                      rsp_if.last_of_run, want.last));
         end
      end
   end

   // ------------------------------------------------------------------
   // traffic generators
   // ------------------------------------------------------------------
   // well-formed frame: new frame, a few scramble words, mostly a flush
   task automatic send_frame();
      int          words;
      logic [3:0]  bc;
      words = $urandom_range(1, 5);
      send_item(OP_SCRAMBLE, 8'($urandom), 4'(word_bits()), 1'b1, 1'($urandom));
      for (int i = 0; i < words; i++) begin
         bc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'(word_bits());
         send_item(OP_SCRAMBLE, 8'($urandom), bc, 1'b0, 1'($urandom));
      end
      if ($urandom_range(0, 3) != 0)
         send_item(OP_FLUSH, 8'($urandom), 4'($urandom), 1'b0, 1'($urandom));
   endtask

   task automatic send_bytes();
      int         n;
      logic [3:0] bc;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         bc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'(BYTE_BITS);
         send_item(OP_DESCRAMBLE, 8'($urandom), bc, 1'($urandom), 1'($urandom));
      end
   endtask

   // mix of frames, descramble bursts and raw noise, n counted items
   task automatic run_traffic(input int n);
      int start;
      int pick;
      start = items_count;
      while (items_count - start < n) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) send_frame();
         else if (pick < 8) send_bytes();
         else send_item(2'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                        1'($urandom));
         if ($urandom_range(0, 11) == 0) pause_for_results();
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset values: polynomial 3, no delay, 8-bit words, all-ones register
   task automatic test_reset_state();
      send_item(OP_SCRAMBLE, 8'h00, 4'd8, 1'b0, 1'b0);
      send_item(OP_SCRAMBLE, 8'hFF, 4'd8, 1'b0, 1'b0);
      send_item(OP_DESCRAMBLE, 8'hA5, 4'd8, 1'b0, 1'b0);
      // flush with nothing pending returns no word
      send_item(OP_FLUSH, 8'h00, 4'd8, 1'b0, 1'b0);
      // partial word then flush
      send_item(OP_SCRAMBLE, 8'hE0, 4'd3, 1'b0, 1'b0);
      send_item(OP_FLUSH, 8'h00, 4'd8, 1'b0, 1'b0);
   endtask

   task automatic test_directed();
      // taps 17 and 12: output delay of 5
      apply_settings(32'h0002_1001, 1'b0, 4'd8);
      // primed frame suppresses the first delay bits
      send_item(OP_SCRAMBLE, 8'hFF, 4'd8, 1'b1, 1'b1);
      send_item(OP_SCRAMBLE, 8'h00, 4'd8, 1'b0, 1'b0);
      send_item(OP_FLUSH, 8'h00, 4'd8, 1'b0, 1'b0);
      // unprimed frame: no suppression
      send_item(OP_SCRAMBLE, 8'h5A, 4'd8, 1'b1, 1'b0);
      // zero count does nothing, oversize count is clamped
      send_item(OP_SCRAMBLE, 8'hC3, 4'd0, 1'b0, 1'b0);
      send_item(OP_SCRAMBLE, 8'h81, 4'd15, 1'b0, 1'b0);
      send_item(OP_SCRAMBLE, 8'h80, 4'd1, 1'b0, 1'b0);
      // new frame on a flush: primed pushes nothing out, unprimed emits
      send_item(OP_FLUSH, 8'h00, 4'd8, 1'b1, 1'b1);
      send_item(OP_FLUSH, 8'hFF, 4'd8, 1'b1, 1'b0);
      // descramble extremes; new_call and prime have no effect here
      send_item(OP_DESCRAMBLE, 8'h00, 4'd8, 1'b0, 1'b0);
      send_item(OP_DESCRAMBLE, 8'hFF, 4'd8, 1'b1, 1'b1);
      send_item(OP_DESCRAMBLE, 8'hFF, 4'd0, 1'b0, 1'b0);
      send_item(OP_DESCRAMBLE, 8'h80, 4'd1, 1'b0, 1'b0);
      send_item(OP_DESCRAMBLE, 8'h3C, 4'd15, 1'b0, 1'b0);
      // unused opcode: no word and no new frame
      send_item(OP_UNUSED, 8'hFF, 4'd15, 1'b1, 1'b1);
      send_item(OP_SCRAMBLE, 8'hF0, 4'd8, 1'b0, 1'b0);
      send_item(OP_FLUSH, 8'h00, 4'd8, 1'b0, 1'b0);
      // inverted data, 3-bit words
      apply_settings(32'h0002_1001, 1'b1, 4'd3);
      send_item(OP_SCRAMBLE, 8'h07, 4'd3, 1'b1, 1'b1);
      send_item(OP_SCRAMBLE, 8'h00, 4'd8, 1'b0, 1'b0);
      send_item(OP_DESCRAMBLE, 8'hFF, 4'd8, 1'b0, 1'b0);
      send_item(OP_FLUSH, 8'h00, 4'd8, 1'b0, 1'b0);
   endtask

   // degenerate tap sets and out-of-range word widths
   task automatic test_tap_corners();
      logic [31:0] polys[9];
      logic [3:0]  widths[9];
      polys  = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h4000_0000,
                 32'h8000_0000, 32'hC000_0001, 32'hFFFF_FFFF, 32'h4000_0003,
                 32'h7FFF_FFFF};
      widths = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15, 4'd2, 4'd1, 4'd1, 4'd8};
      foreach (polys[i]) begin
         apply_settings(polys[i], 1'(i), widths[i]);
         send_frame();
         send_bytes();
      end
   endtask

   // random settings, extremes mixed in
   task automatic test_random_settings();
      logic [31:0] known[5];
      logic [31:0] poly;
      int          start;
      known = '{32'h0002_1001, 32'h0000_0089, 32'h0000_0003, 32'h0080_0021,
                32'h4000_0003};
      start = items_count;
      while (items_count - start < RANDOM_ITEMS) begin
         poly = ($urandom_range(0, 1) == 0) ? known[$urandom_range(0, 4)] : $urandom;
         apply_settings(poly, 1'($urandom), 4'($urandom_range(0, 15)));
         run_traffic(10);
      end
   endtask

   // full rate on both sides
   task automatic test_full_rate();
      apply_settings(32'h0002_1001, 1'b0, 4'd8);
      no_idle = 1'b1;
      run_traffic(30);
      settle();
      no_idle = 1'b0;
   endtask

   initial begin
      reset        <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_SCRAMBLE;
      req_if.data      <= 8'd0;
      req_if.bit_count <= 4'd0;
      req_if.new_call  <= 1'b0;
      req_if.prime     <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      // predictor reset state
      cfg_poly = 32'd3;
      cfg_inv  = 1'b0;
      cfg_ww   = 4'd8;
      sr       = 32'hFFFF_FFFF;
      dcount   = 6'd0;
      pword    = 8'd0;
      pbits    = 4'd0;
      derive_taps();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed();
      test_tap_corners();
      test_random_settings();
      test_full_rate();

      settle();
      if (mismatch_count == 0 && due_words.size() == 0) begin
         $display("PASS self_sync_scrambler_descrambler");
      end else begin
         $display("FAIL self_sync_scrambler_descrambler");
      end
      $finish;
   end

   // run limit, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL self_sync_scrambler_descrambler");
      $finish;
   end

endmodule

/* self_sync_scrambler_descrambler.f */
design/sssd_pkg.sv
design/sssd_if.sv
design/sssd_csr.sv
design/sssd_tap_scan.sv
design/sssd_engine.sv
design/self_sync_scrambler_descrambler.sv
test/testbench.sv
